// ===== design/dpls_pkg.sv =====
package dpls_pkg;

    // Coordinate precision. Endpoints use only their low COORD_BITS bits, as a signed value.
    localparam int COORD_BITS   = 16;
    localparam int FIELD_BITS   = 16;
    localparam int SPACING_BITS = 8;
    localparam int PCT_BITS     = 7;
    localparam int PCT_MAX      = 100;
    localparam int ERR_BITS     = 32;
    localparam int INC_BITS     = 16;
    localparam int PHASE_BITS   = SPACING_BITS + 1;

    // The length fraction is applied as amaj * ceil(pct * 2^PCT_SHIFT / 100) >> PCT_SHIFT.
    // 2^PCT_SHIFT is above 100 * 2^COORD_BITS, so the rounding error stays under 1/100
    // and the truncated quotient is exact.
    localparam int PCT_SHIFT      = COORD_BITS + 7;
    localparam int PCT_SCALE_BITS = PCT_SHIFT + 1;
    localparam int PCT_NUM_BITS   = PCT_SHIFT + PCT_BITS + 1;
    localparam int PROD_BITS      = COORD_BITS + PCT_SCALE_BITS;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef struct packed {
        logic                          command;
        logic signed [FIELD_BITS-1:0]  x_start;
        logic signed [FIELD_BITS-1:0]  y_start;
        logic signed [FIELD_BITS-1:0]  x_end;
        logic signed [FIELD_BITS-1:0]  y_end;
        logic        [SPACING_BITS-1:0] spacing;
        logic        [PCT_BITS-1:0]    percent;
    } dpls_in_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] point_x;
        logic signed [FIELD_BITS-1:0] point_y;
        logic                         plot;
        logic                         last;
    } dpls_out_t;

    typedef logic [(2**PCT_BITS)-1:0][PCT_SCALE_BITS-1:0] pct_scale_tab_t;

    // Builds the scale factor for every percent code at elaboration time.
    function automatic pct_scale_tab_t build_pct_scale_tab();
        pct_scale_tab_t          tab;
        logic [PCT_NUM_BITS-1:0] num;
        for (int i = 0; i < 2**PCT_BITS; i++)
        begin
            num    = (PCT_NUM_BITS'(i) << PCT_SHIFT) + PCT_NUM_BITS'(PCT_MAX - 1);
            tab[i] = PCT_SCALE_BITS'(num / PCT_NUM_BITS'(PCT_MAX));
        end
        return tab;
    endfunction

    localparam pct_scale_tab_t PCT_SCALE_TAB = build_pct_scale_tab();

    // Scale factor for a clamped percentage; a 128-entry constant table.
    function automatic logic [PCT_SCALE_BITS-1:0] pct_scale(input logic [PCT_BITS-1:0] pct);
        return PCT_SCALE_TAB[pct];
    endfunction

    // Sign-extends a coordinate into an output field.
    function automatic logic signed [FIELD_BITS-1:0] out_coord(
        input logic signed [COORD_BITS-1:0] v
    );
        return FIELD_BITS'(v);
    endfunction

    // True while the major coordinate has not yet passed the end of the walk.
    function automatic logic walk_on(
        input logic signed [COORD_BITS:0]   cur,
        input logic signed [COORD_BITS-1:0] last_major,
        input logic                         rev
    );
        logic signed [COORD_BITS:0] end_ext;
        end_ext = (COORD_BITS+1)'(last_major);
        return rev ? (cur >= end_ext) : (cur <= end_ext);
    endfunction

endpackage

// ===== design/dpls_in_if.sv =====
interface dpls_in_if
    import dpls_pkg::*;
();
    logic     valid;
    logic     ready;
    dpls_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/dpls_out_if.sv =====
interface dpls_out_if
    import dpls_pkg::*;
();
    logic      valid;
    logic      ready;
    dpls_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/dotted_partial_line_stepper.sv =====
// Dotted, partial line stepper. A start item latches two endpoints, a dot spacing and a
// length percentage and answers with one item whose last flag says whether the walk is
// already empty. Each step item then advances one pixel along the major axis and answers
// with that pixel, a plot flag for every (spacing+1)th pixel, and last once the walk ends;
// a step while no walk is running answers with last set and changes nothing. The block
// takes one item per clock cycle, sustained, while the receiver is ready. An accepted
// item sits in the input register, then the line setup or the Bresenham update (one
// 16 by 24 bit multiply for the length fraction, or one 32 bit error add) runs into the
// result register, and the input register can take a new item while an answer waits.
module dotted_partial_line_stepper
    import dpls_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    dpls_in_if.sink      req,
    dpls_out_if.source   rsp
);

    // Handshake and pipeline registers.
    logic      s1_valid_reg;
    dpls_in_t  s1_data_reg;
    logic      out_valid_reg;
    dpls_out_t out_data_reg;
    logic      s1_take;

    // Walk state.
    logic                             active_reg;
    logic                             x_major_reg;
    logic                             reversed_reg;
    logic signed [COORD_BITS:0]       cur_major_reg;
    logic signed [COORD_BITS-1:0]     cur_minor_reg;
    logic signed [COORD_BITS-1:0]     walk_end_reg;
    logic        [ERR_BITS-1:0]       error_term_reg;
    logic signed [1:0]                minor_dir_reg;
    logic signed [INC_BITS-1:0]       inc_diagonal_reg;
    logic signed [INC_BITS-1:0]       inc_straight_reg;
    logic        [PHASE_BITS-1:0]     dot_phase_reg;
    logic        [SPACING_BITS-1:0]   dot_spacing_reg;

    logic                             active_next;
    logic                             x_major_next;
    logic                             reversed_next;
    logic signed [COORD_BITS:0]       cur_major_next;
    logic signed [COORD_BITS-1:0]     cur_minor_next;
    logic signed [COORD_BITS-1:0]     walk_end_next;
    logic        [ERR_BITS-1:0]       error_term_next;
    logic signed [1:0]                minor_dir_next;
    logic signed [INC_BITS-1:0]       inc_diagonal_next;
    logic signed [INC_BITS-1:0]       inc_straight_next;
    logic        [PHASE_BITS-1:0]     dot_phase_next;
    logic        [SPACING_BITS-1:0]   dot_spacing_next;
    dpls_out_t                        result_next;

    // Line setup terms.
    logic signed [COORD_BITS-1:0]     xs, ys, xe, ye;
    logic signed [COORD_BITS:0]       dx, dy, dmaj, dmin;
    logic        [COORD_BITS-1:0]     adx, ady, amaj, amin;
    logic signed [COORD_BITS-1:0]     smaj, smin;
    logic                             st_x_major;
    logic                             st_reversed;
    logic        [PCT_BITS-1:0]       pct_clamped;
    logic        [PROD_BITS-1:0]      span_prod;
    logic        [COORD_BITS-1:0]     span_part;
    logic signed [COORD_BITS:0]       span_offset;
    logic signed [COORD_BITS:0]       smaj_ext;
    logic signed [COORD_BITS-1:0]     st_walk_end;
    logic signed [COORD_BITS:0]       st_cur_major;
    logic                             st_active;

    // Step terms.
    logic                             err_positive;
    logic        [PHASE_BITS-1:0]     phase_inc;
    logic                             dot_hit;
    logic signed [COORD_BITS-1:0]     minor_moved;
    logic signed [COORD_BITS:0]       major_moved;

    assign s1_take   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_take;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Start: pick the major axis and derive the Bresenham terms and the end of the walk.
    always_comb
    begin
        xs = s1_data_reg.x_start[COORD_BITS-1:0];
        ys = s1_data_reg.y_start[COORD_BITS-1:0];
        xe = s1_data_reg.x_end[COORD_BITS-1:0];
        ye = s1_data_reg.y_end[COORD_BITS-1:0];
        dx = (COORD_BITS+1)'(xe) - (COORD_BITS+1)'(xs);
        dy = (COORD_BITS+1)'(ye) - (COORD_BITS+1)'(ys);
        adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
        st_x_major = (dx != '0) && (ady < adx);
        if (st_x_major)
        begin
            dmaj = dx;  dmin = dy;  amaj = adx; amin = ady; smaj = xs; smin = ys;
        end
        else
        begin
            dmaj = dy;  dmin = dx;  amaj = ady; amin = adx; smaj = ys; smin = xs;
        end
        st_reversed = dmaj[COORD_BITS];

        pct_clamped = (s1_data_reg.percent > PCT_BITS'(PCT_MAX)) ?
                      PCT_BITS'(PCT_MAX) : s1_data_reg.percent;
        span_prod   = PROD_BITS'(amaj) * PROD_BITS'(pct_scale(pct_clamped));
        span_part   = span_prod[PCT_SHIFT +: COORD_BITS];
        span_offset = st_reversed ? -$signed({1'b0, span_part}) : $signed({1'b0, span_part});
        smaj_ext    = (COORD_BITS+1)'(smaj);
        st_walk_end = COORD_BITS'(smaj_ext + span_offset);
        // The walk begins one above the start on the major axis, in either direction.
        st_cur_major = smaj_ext + (COORD_BITS+1)'(1);
        st_active    = walk_on(st_cur_major, st_walk_end, st_reversed);
    end

    // Step: one Bresenham update and the dot counter.
    always_comb
    begin
        err_positive = (error_term_reg != '0) && !error_term_reg[ERR_BITS-1];
        phase_inc    = dot_phase_reg + PHASE_BITS'(1);
        dot_hit      = PHASE_BITS'(dot_spacing_reg) < phase_inc;
        minor_moved  = err_positive ? cur_minor_reg + COORD_BITS'(minor_dir_reg) : cur_minor_reg;
        major_moved  = reversed_reg ? cur_major_reg - (COORD_BITS+1)'(1)
                                    : cur_major_reg + (COORD_BITS+1)'(1);
    end

    always_comb
    begin
        active_next       = active_reg;
        x_major_next      = x_major_reg;
        reversed_next     = reversed_reg;
        cur_major_next    = cur_major_reg;
        cur_minor_next    = cur_minor_reg;
        walk_end_next     = walk_end_reg;
        error_term_next   = error_term_reg;
        minor_dir_next    = minor_dir_reg;
        inc_diagonal_next = inc_diagonal_reg;
        inc_straight_next = inc_straight_reg;
        dot_phase_next    = dot_phase_reg;
        dot_spacing_next  = dot_spacing_reg;
        result_next       = '{point_x: '0, point_y: '0, plot: 1'b0, last: 1'b1};

        unique case (s1_data_reg.command)
            CMD_START:
            begin
                active_next       = st_active;
                x_major_next      = st_x_major;
                reversed_next     = st_reversed;
                cur_major_next    = st_cur_major;
                cur_minor_next    = smin;
                walk_end_next     = st_walk_end;
                error_term_next   = ERR_BITS'({amin, 1'b0}) - ERR_BITS'(amaj);
                minor_dir_next    = (dmin == '0) ? 2'sd0 : (dmin[COORD_BITS] ? -2'sd1 : 2'sd1);
                inc_straight_next = INC_BITS'({amin, 1'b0});
                inc_diagonal_next = INC_BITS'({amin, 1'b0}) - INC_BITS'({amaj, 1'b0});
                dot_phase_next    = st_x_major ? PHASE_BITS'(1) : '0;
                dot_spacing_next  = s1_data_reg.spacing;
                result_next.last  = !st_active;
            end
            CMD_STEP:
            begin
                if (active_reg)
                begin
                    cur_minor_next  = minor_moved;
                    error_term_next = error_term_reg + (err_positive ?
                                      ERR_BITS'(inc_diagonal_reg) : ERR_BITS'(inc_straight_reg));
                    dot_phase_next  = dot_hit ? '0 : phase_inc;
                    cur_major_next  = major_moved;
                    active_next     = walk_on(major_moved, walk_end_reg, reversed_reg);
                    result_next.plot = dot_hit;
                    result_next.last = !active_next;
                    if (x_major_reg)
                    begin
                        result_next.point_x = out_coord(cur_major_reg[COORD_BITS-1:0]);
                        result_next.point_y = out_coord(minor_moved);
                    end
                    else
                    begin
                        result_next.point_x = out_coord(minor_moved);
                        result_next.point_y = out_coord(cur_major_reg[COORD_BITS-1:0]);
                    end
                end
            end
            default:
            begin
                result_next.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            active_reg       <= 1'b0;
            x_major_reg      <= 1'b0;
            reversed_reg     <= 1'b0;
            cur_major_reg    <= '0;
            cur_minor_reg    <= '0;
            walk_end_reg     <= '0;
            error_term_reg   <= '0;
            minor_dir_reg    <= '0;
            inc_diagonal_reg <= '0;
            inc_straight_reg <= '0;
            dot_phase_reg    <= '0;
            dot_spacing_reg  <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_take)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_take)
            begin
                out_valid_reg    <= 1'b1;
                active_reg       <= active_next;
                x_major_reg      <= x_major_next;
                reversed_reg     <= reversed_next;
                cur_major_reg    <= cur_major_next;
                cur_minor_reg    <= cur_minor_next;
                walk_end_reg     <= walk_end_next;
                error_term_reg   <= error_term_next;
                minor_dir_reg    <= minor_dir_next;
                inc_diagonal_reg <= inc_diagonal_next;
                inc_straight_reg <= inc_straight_next;
                dot_phase_reg    <= dot_phase_next;
                dot_spacing_reg  <= dot_spacing_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_data_reg <= req.data;
        end
        if (s1_take)
        begin
            out_data_reg <= result_next;
        end
    end

    // The last flag of a fresh answer agrees with the walk state left behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_take |=> (out_data_reg.last == !active_reg))
        else $error("last flag disagrees with walk state");

    // A running walk never sits past its end.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> walk_on(cur_major_reg, walk_end_reg, reversed_reg))
        else $error("active walk is past its end");

    // A start item answers with an unplotted origin point.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_take && s1_data_reg.command == CMD_START) |=>
        (!out_data_reg.plot && out_data_reg.point_x == '0 && out_data_reg.point_y == '0))
        else $error("start item produced a point");

    // A step with no walk running leaves the walk state alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_take && s1_data_reg.command == CMD_STEP && !active_reg) |=>
        ($stable(cur_major_reg) && $stable(error_term_reg) && $stable(dot_phase_reg)
         && out_data_reg.last && !out_data_reg.plot))
        else $error("idle step changed the walk");

endmodule

// ===== tb/sv/tb_dotted_partial_line_stepper.sv =====
module tb_dotted_partial_line_stepper;
    timeunit 1ns;
    timeprecision 1ps;

    import dpls_pkg::*;

    // Cycles with no item moving on either channel before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    // Number of random items, split over the three flow-control mixes.
    localparam int RANDOM_ITEMS  = 400;
    // Cycles waited at the end of the run; a wide margin over the block's answer time.
    localparam int SETTLE_CYCLES = 8;

    // Tracks the stepper state and holds the pixels still owed by the block.
    class pixel_ledger;
        dpls_out_t pending_pixels[$];

        bit                          walking;
        bit                          along_x;
        bit                          backward;
        int                          cur_major;
        int                          cur_minor;
        int                          walk_end;
        int                          minor_step;
        int                          err_acc;
        bit signed [INC_BITS-1:0]    inc_diag;
        bit signed [INC_BITS-1:0]    inc_flat;
        bit [15:0]                   dot_phase;
        bit [SPACING_BITS-1:0]       dot_gap;

        int n_errors;
        int n_checked;
        int n_starts;
        int n_steps;
        int n_idle_steps;
        int n_plots;
        int n_backward;
        int n_along_x;
        int n_empty;

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function bit still_walking();
            return backward ? (cur_major >= walk_end) : (cur_major <= walk_end);
        endfunction

        // Keeps the low COORD_BITS of a coordinate and sign-extends them into the field.
        function logic signed [FIELD_BITS-1:0] to_field(int v);
            logic signed [COORD_BITS-1:0] c;
            c = v[COORD_BITS-1:0];
            return FIELD_BITS'(c);
        endfunction

        // Works out the pixel that an accepted item must produce and queues it.
        function void note_command(dpls_in_t cmd);
            dpls_out_t px;
            int xs, ys, xe, ye, pct, dx, dy;
            int dmaj, dmin, smaj, emaj, smin, amaj, amin;
            px = '0;
            px.last = 1'b1;
            if (cmd.command == CMD_START)
            begin
                xs = int'($signed(cmd.x_start[COORD_BITS-1:0]));
                ys = int'($signed(cmd.y_start[COORD_BITS-1:0]));
                xe = int'($signed(cmd.x_end[COORD_BITS-1:0]));
                ye = int'($signed(cmd.y_end[COORD_BITS-1:0]));
                pct = (cmd.percent > PCT_MAX) ? PCT_MAX : int'(cmd.percent);
                dx = xe - xs;
                dy = ye - ys;
                dot_gap = cmd.spacing;
                along_x = (dx != 0) && (magnitude(dy) < magnitude(dx));
                if (along_x)
                begin
                    dmaj = dx;
                    dmin = dy;
                    smaj = xs;
                    emaj = xe;
                    smin = ys;
                    dot_phase = 1;
                end
                else
                begin
                    dmaj = dy;
                    dmin = dx;
                    smaj = ys;
                    emaj = ye;
                    smin = xs;
                    dot_phase = 0;
                end
                backward = dmaj < 0;
                minor_step = (dmin > 0) ? 1 : ((dmin < 0) ? -1 : 0);
                amaj = magnitude(dmaj);
                amin = magnitude(dmin);
                err_acc = 2 * amin - amaj;
                inc_flat = INC_BITS'(2 * amin);
                inc_diag = INC_BITS'(2 * (amin - amaj));
                walk_end = smaj + ((emaj - smaj) * pct) / PCT_MAX;
                cur_major = smaj + 1;
                cur_minor = smin;
                walking = still_walking();
                px.last = !walking;
                n_starts++;
                n_along_x += along_x;
                n_backward += backward;
                n_empty += !walking;
            end
            else if (walking)
            begin
                dot_phase = dot_phase + 1;
                if (err_acc > 0)
                begin
                    cur_minor += minor_step;
                    err_acc += int'(inc_diag);
                end
                else
                begin
                    err_acc += int'(inc_flat);
                end
                if (dot_gap < dot_phase)
                begin
                    px.plot = 1'b1;
                    dot_phase = 0;
                    n_plots++;
                end
                if (along_x)
                begin
                    px.point_x = to_field(cur_major);
                    px.point_y = to_field(cur_minor);
                end
                else
                begin
                    px.point_x = to_field(cur_minor);
                    px.point_y = to_field(cur_major);
                end
                cur_major += backward ? -1 : 1;
                walking = still_walking();
                px.last = !walking;
                n_steps++;
            end
            else
            begin
                n_idle_steps++;
            end
            pending_pixels.push_back(px);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                n_errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // Compares a returned pixel with the oldest one still owed.
        function void check_pixel(dpls_out_t got);
            dpls_out_t want;
            if (pending_pixels.size() == 0)
            begin
                n_errors++;
                $display("%0t: pixel with nothing owed, got x=%0d y=%0d plot=%0b last=%0b",
                         $time, got.point_x, got.point_y, got.plot, got.last);
                return;
            end
            want = pending_pixels.pop_front();
            n_checked++;
            compare_field("point_x", want.point_x, got.point_x);
            compare_field("point_y", want.point_y, got.point_y);
            compare_field("plot", want.plot, got.plot);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dpls_in_if  req_if ();
    dpls_out_if rsp_if ();

    pixel_ledger ledger = new();

    // Chance, in percent, that the sender or the receiver holds off in a given cycle.
    int src_idle_pct;
    int sink_idle_pct;
    int n_pushed;
    int stall_cycles;

    dotted_partial_line_stepper i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The receiver: ready changes on the falling edge, held low through reset.
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n !== 1'b1)
                rsp_if.ready <= 1'b0;
            else
                rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Both channels are sampled at the rising edge, before the block updates its outputs.
    // Commands are noted first; a pixel can never belong to a command accepted on the
    // same edge, since the answer passes through the input and the result register.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (req_if.valid && req_if.ready)
                ledger.note_command(req_if.data);
            if (rsp_if.valid && rsp_if.ready)
                ledger.check_pixel(rsp_if.data);
        end
    end

    // Ends the run if neither channel moves for too long.
    initial
    begin
        stall_cycles = 0;
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // A command with every field random; step items carry junk the block should ignore.
    function automatic dpls_in_t random_payload(logic cmd_code);
        dpls_in_t p;
        p.command = cmd_code;
        p.x_start = FIELD_BITS'($urandom);
        p.y_start = FIELD_BITS'($urandom);
        p.x_end   = FIELD_BITS'($urandom);
        p.y_end   = FIELD_BITS'($urandom);
        p.spacing = SPACING_BITS'($urandom);
        p.percent = PCT_BITS'($urandom);
        return p;
    endfunction

    // Offers one item, with random hold-offs first, and returns at the falling edge after
    // it was taken. Called and returning at a falling edge, so valid is assigned at most
    // once per time step.
    task automatic push_command(input dpls_in_t cmd);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            req_if.data  <= random_payload(1'($urandom));
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= cmd;
        n_pushed++;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic start_line(input int xs, input int ys, input int xe, input int ye,
                              input int sp, input int pct);
        dpls_in_t cmd;
        cmd = random_payload(CMD_START);
        cmd.x_start = FIELD_BITS'(xs);
        cmd.y_start = FIELD_BITS'(ys);
        cmd.x_end   = FIELD_BITS'(xe);
        cmd.y_end   = FIELD_BITS'(ye);
        cmd.spacing = SPACING_BITS'(sp);
        cmd.percent = PCT_BITS'(pct);
        push_command(cmd);
    endtask

    task automatic step_line(input int count);
        repeat (count)
            push_command(random_payload(CMD_STEP));
    endtask

    // A well-formed line: short spans near the origin most of the time, with flat, steep
    // and diagonal lines mixed in, then steps until the walk ends. Some walks are cut off
    // by the next start, and some are followed by steps into an idle stepper.
    task automatic walk_random_line();
        dpls_in_t cmd;
        int reach, span_x, span_y, cap, taken, pick;
        cmd = random_payload(CMD_START);
        reach = ($urandom_range(9) == 0) ? 400 : 12;
        if ($urandom_range(9) < 7)
        begin
            cmd.x_start = FIELD_BITS'(int'($urandom_range(100)) - 50);
            cmd.y_start = FIELD_BITS'(int'($urandom_range(100)) - 50);
        end
        span_x = int'($urandom_range(2 * reach)) - reach;
        span_y = int'($urandom_range(2 * reach)) - reach;
        case ($urandom_range(9))
            0: span_y = 0;
            1: span_x = 0;
            2: span_y = $urandom_range(1) ? span_x : -span_x;
            default: ;
        endcase
        cmd.x_end = cmd.x_start + FIELD_BITS'(span_x);
        cmd.y_end = cmd.y_start + FIELD_BITS'(span_y);
        if ($urandom_range(9) < 7)
            cmd.spacing = SPACING_BITS'($urandom_range(3));
        pick = $urandom_range(19);
        if (pick < 12)
            cmd.percent = PCT_BITS'(PCT_MAX);
        else if (pick < 17)
            cmd.percent = PCT_BITS'($urandom_range(PCT_MAX));
        push_command(cmd);

        // The ledger has already seen the start, so it tells how long the walk runs.
        cap = ($urandom_range(4) == 0) ? $urandom_range(3) : 64;
        taken = 0;
        while (ledger.walking && taken < cap)
        begin
            step_line(1);
            taken++;
        end
        if ($urandom_range(3) == 0)
            step_line($urandom_range(2, 1));
    endtask

    // Noise: a command with all fields random, possibly a huge or empty line, and a few
    // steps after it.
    task automatic push_noise();
        push_command(random_payload(1'($urandom)));
        step_line($urandom_range(3));
    endtask

    task automatic run_random(input int budget);
        int target;
        target = n_pushed + budget;
        while (n_pushed < target)
        begin
            if ($urandom_range(4) == 0)
                push_noise();
            else
                walk_random_line();
        end
    endtask

    // The sender holds off until every owed pixel has come back.
    task automatic settle();
        req_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (ledger.pending_pixels.size() != 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        n_pushed = 0;
        src_idle_pct = 29;
        sink_idle_pct <= 68;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed lines. A step right after reset finds the stepper idle.
        step_line(1);
        // A line of zero length has an empty walk.
        start_line(0, 0, 0, 0, 0, PCT_MAX);
        // Corner to corner: equal spans go along y, and a percent above 100 is clamped.
        start_line(-32768, -32768, 32767, 32767, 255, 127);
        step_line(2);
        // Reversed x-major line starting one past the top of the range, so the first
        // pixel wraps around in the output field.
        start_line(32767, 5, -32768, 3, 0, PCT_MAX);
        step_line(2);
        // Steep reversed line with every second pixel drawn.
        start_line(10, 10, 7, 2, 1, PCT_MAX);
        step_line(3);
        // Flat line walked to its end, then one step into the idle stepper.
        start_line(0, 4, 3, 4, 0, PCT_MAX);
        step_line(4);
        // Zero percent leaves nothing to walk.
        start_line(0, 0, 9, 1, 2, 0);
        // Vertical line going down, half of it, cut short by the random part.
        start_line(2, 0, 2, -6, 200, 50);
        step_line(2);
        settle();

        run_random(RANDOM_ITEMS / 3);
        settle();

        src_idle_pct = 68;
        sink_idle_pct <= 29;
        run_random(RANDOM_ITEMS / 3);
        settle();

        src_idle_pct = 0;
        sink_idle_pct <= 0;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        settle();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (ledger.pending_pixels.size() != 0)
        begin
            ledger.n_errors++;
            $display("%0t: %0d pixels never came back", $time, ledger.pending_pixels.size());
        end

        $display("Started %0d lines (%0d along x, %0d reversed, %0d empty), took %0d steps, %0d plotted.",
                 ledger.n_starts, ledger.n_along_x, ledger.n_backward, ledger.n_empty,
                 ledger.n_steps, ledger.n_plots);
        $display("%0d steps hit an idle stepper; %0d pixels checked under three flow-control mixes.",
                 ledger.n_idle_steps, ledger.n_checked);
        if (ledger.n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dpls_pkg.sv
design/dpls_in_if.sv
design/dpls_out_if.sv
design/dotted_partial_line_stepper.sv
tb/sv/tb_dotted_partial_line_stepper.sv
